// ----- rtl/izd_pkg.sv -----
package izd_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned FuncW = 2;
  localparam int unsigned BitsPerStageDef = 4;   // quotient bits per array stage

  typedef enum logic [FuncW-1:0] {
    FUNC_S32 = 2'd0,
    FUNC_U32 = 2'd1,
    FUNC_S64 = 2'd2,
    FUNC_U64 = 2'd3
  } func_t;

  // Control fields from sign handling and special cases, carried down the array.
  typedef struct packed {
    logic             zero_div;   // divisor is zero
    logic             q_neg;      // negate quotient at the end
    logic             r_neg;      // negate remainder at the end
    logic             is32;       // 32-bit mode, mask results
    logic [DataW-1:0] sat_q;      // quotient to give on zero divisor
  } ctl_t;
endpackage

// ----- rtl/izd_if.sv -----
interface izd_in_if;
  import izd_pkg::*;
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [DataW-1:0] dividend;
  logic [DataW-1:0] divisor;
  modport source(output valid, func, dividend, divisor, input ready);
  modport sink(input valid, func, dividend, divisor, output ready);
endinterface

interface izd_out_if;
  import izd_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] quotient;
  logic [DataW-1:0] remainder;
  modport source(output valid, quotient, remainder, input ready);
  modport sink(input valid, quotient, remainder, output ready);
endinterface

// ----- rtl/izd_prep.sv -----
// Operand preparation: sign extension, magnitudes, special-case flags.
module izd_prep (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [izd_pkg::FuncW-1:0] func,
  input  logic [izd_pkg::DataW-1:0] dividend,
  input  logic [izd_pkg::DataW-1:0] divisor,
  output logic                      valid,
  output logic [izd_pkg::DataW-1:0] n_mag,
  output logic [izd_pkg::DataW-1:0] d_mag,
  output izd_pkg::ctl_t             ctl
);
  import izd_pkg::*;

  logic [DataW-1:0] n_ext, d_ext, sat;
  logic             sgn, n_neg, d_neg;
  func_t            f;

  always_comb begin
    f     = func_t'(func);
    sgn   = (f == FUNC_S32) || (f == FUNC_S64);
    n_ext = dividend;
    d_ext = divisor;
    case (f)
      FUNC_S32: begin
        n_ext = {{32{dividend[31]}}, dividend[31:0]};
        d_ext = {{32{divisor[31]}}, divisor[31:0]};
      end
      FUNC_U32: begin
        n_ext = {32'd0, dividend[31:0]};
        d_ext = {32'd0, divisor[31:0]};
      end
      default: ;
    endcase
    n_neg = sgn && n_ext[DataW-1];
    d_neg = sgn && d_ext[DataW-1];
    case (f)
      FUNC_S32: sat = n_neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
      FUNC_U32: sat = 64'h0000_0000_FFFF_FFFF;
      FUNC_S64: sat = n_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      default:  sat = '1;
    endcase
    if (n_ext == '0) sat = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
    if (en) begin
      n_mag        <= n_neg ? DataW'(0) - n_ext : n_ext;
      d_mag        <= d_neg ? DataW'(0) - d_ext : d_ext;
      ctl.zero_div <= (d_ext == '0);
      ctl.q_neg    <= n_neg ^ d_neg;
      ctl.r_neg    <= n_neg;
      ctl.is32     <= (f == FUNC_S32) || (f == FUNC_U32);
      ctl.sat_q    <= sat;
    end
  end
endmodule

// ----- rtl/izd_stage.sv -----
// One pipeline stage of the restoring array: BITS quotient bits per stage.
module izd_stage #(
  parameter int unsigned BITS = izd_pkg::BitsPerStageDef
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [izd_pkg::DataW-1:0] in_n,   // dividend bits left, shifts out
  input  logic [izd_pkg::DataW-1:0] in_r,   // partial remainder
  input  logic [izd_pkg::DataW-1:0] in_d,
  input  izd_pkg::ctl_t             in_ctl,
  output logic                      valid,
  output logic [izd_pkg::DataW-1:0] n,
  output logic [izd_pkg::DataW-1:0] r,
  output logic [izd_pkg::DataW-1:0] d,
  output izd_pkg::ctl_t             ctl
);
  import izd_pkg::*;

  logic [DataW-1:0] n_w, r_w;
  logic [DataW:0]   t, diff;

  always_comb begin
    n_w = in_n;
    r_w = in_r;
    for (int i = 0; i < BITS; i++) begin
      t    = {r_w, n_w[DataW-1]};
      diff = t - {1'b0, in_d};
      n_w  = {n_w[DataW-2:0], 1'b0};
      if (!diff[DataW]) begin
        r_w    = diff[DataW-1:0];
        n_w[0] = 1'b1;        // quotient bit fills in from the right
      end else begin
        r_w    = t[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
    if (en) begin
      n   <= n_w;
      r   <= r_w;
      d   <= in_d;
      ctl <= in_ctl;
    end
  end
endmodule

// ----- rtl/izd_fix.sv -----
// Result fix-up: sign restore, zero-divisor saturation, 32-bit masking.
module izd_fix (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [izd_pkg::DataW-1:0] q_mag,
  input  logic [izd_pkg::DataW-1:0] r_mag,
  input  izd_pkg::ctl_t             in_ctl,
  output logic                      valid,
  output logic [izd_pkg::DataW-1:0] quotient,
  output logic [izd_pkg::DataW-1:0] remainder
);
  import izd_pkg::*;

  logic [DataW-1:0] q_w, r_w;

  always_comb begin
    q_w = in_ctl.q_neg ? DataW'(0) - q_mag : q_mag;
    r_w = in_ctl.r_neg ? DataW'(0) - r_mag : r_mag;
    if (in_ctl.zero_div) begin
      q_w = in_ctl.sat_q;
      r_w = '0;
    end
    if (in_ctl.is32) begin
      q_w[DataW-1:32] = '0;
      r_w[DataW-1:32] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
    if (en) begin
      quotient  <= q_w;
      remainder <= r_w;
    end
  end
endmodule

// ----- rtl/integer_divider_zero_saturating.sv -----
// Pipelined integer divider, signed or unsigned, 32 or 64 bits.
// Input channel (in): func, dividend, divisor. func selects signed 32,
// unsigned 32, signed 64 or unsigned 64. Output channel (out): quotient
// (truncated toward zero) and remainder (sign of dividend), both
// zero-extended in 32-bit modes.
// Zero divisor: quotient saturates (0 for a zero dividend, signed max/min
// or all ones otherwise), remainder 0. Signed min / -1 wraps to min.
// Pipeline: 2 + 64/BitsPerStage register stages (prep, array, fix).
// Throughput: one beat per cycle unless the receiver stalls; every
// stage holds its own beat.
// The whole pipe advances together: when the receiver stalls with a beat
// waiting in the output register, in.ready drops and every stage holds,
// so nothing is lost or repeated. Bubbles are not squeezed out while
// stalled.
// Reset (rst, synchronous) clears every valid bit; data registers keep
// whatever they held.
module integer_divider_zero_saturating #(
  parameter int unsigned BitsPerStage = izd_pkg::BitsPerStageDef
) (
  input  logic       clk,
  input  logic       rst,
  izd_in_if.sink     in,
  izd_out_if.source  out
);
  import izd_pkg::*;

  localparam int unsigned Stages = DataW / BitsPerStage;

  logic               pv  [Stages+1];
  logic [DataW-1:0]   pn  [Stages+1];
  logic [DataW-1:0]   pr  [Stages+1];
  logic [DataW-1:0]   pd  [Stages+1];
  ctl_t               pc  [Stages+1];
  logic               en;

  // Advance whenever the output slot is free or being taken.
  assign en       = !out.valid || out.ready;
  assign in.ready = en;

  izd_prep u_prep (
    .clk, .rst, .en,
    .in_valid (in.valid),
    .func     (in.func),
    .dividend (in.dividend),
    .divisor  (in.divisor),
    .valid    (pv[0]),
    .n_mag    (pn[0]),
    .d_mag    (pd[0]),
    .ctl      (pc[0])
  );
  assign pr[0] = '0;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    izd_stage #(.BITS(BitsPerStage)) u_stage (
      .clk, .rst, .en,
      .in_valid (pv[s]),
      .in_n     (pn[s]),
      .in_r     (pr[s]),
      .in_d     (pd[s]),
      .in_ctl   (pc[s]),
      .valid    (pv[s+1]),
      .n        (pn[s+1]),
      .r        (pr[s+1]),
      .d        (pd[s+1]),
      .ctl      (pc[s+1])
    );
  end

  izd_fix u_fix (
    .clk, .rst, .en,
    .in_valid  (pv[Stages]),
    .q_mag     (pn[Stages]),
    .r_mag     (pr[Stages]),
    .in_ctl    (pc[Stages]),
    .valid     (out.valid),
    .quotient  (out.quotient),
    .remainder (out.remainder)
  );
endmodule

// ----- test/integer_divider_zero_saturating_tb.sv -----
`timescale 1ns / 1ps

// Testbench for the pipelined zero-saturating integer divider.
// A scoreboard object holds the quotient/remainder pairs predicted for
// every accepted input beat; each output beat is checked against the
// oldest one. Drivers change inputs on the falling edge, monitors sample
// on the rising edge.
module integer_divider_zero_saturating_tb;
  import izd_pkg::*;

  localparam int NumRandom = 600;
  localparam int CycleLimit = 400000;
  localparam logic [63:0] Low32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] Min64 = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] quo;
    logic [63:0] rem;
  } div_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  izd_in_if  in_ch();
  izd_out_if out_ch();

  integer_divider_zero_saturating dut (
    .clk(clk),
    .rst(rst),
    .in (in_ch.sink),
    .out(out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;      // no idling on either side once set
  int n_zero_div = 0;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // Signed divide of 64-bit raw bits; maxv/minv saturate on a zero divisor.
  function automatic div_result_t divide_signed(logic [63:0] n, logic [63:0] d,
                                                logic [63:0] maxv, logic [63:0] minv);
    div_result_t res;
    logic [63:0] nm, dm, qm, rm;
    if (d == 64'd0) begin
      res.quo = (n == 64'd0) ? 64'd0 : (n[63] ? minv : maxv);
      res.rem = 64'd0;
    end else begin
      nm = n[63] ? -n : n;
      dm = d[63] ? -d : d;
      qm = nm / dm;
      rm = nm % dm;
      res.quo = (n[63] != d[63]) ? -qm : qm;
      res.rem = n[63] ? -rm : rm;
    end
    return res;
  endfunction

  function automatic div_result_t divide_unsigned(logic [63:0] n, logic [63:0] d,
                                                  logic [63:0] ones);
    div_result_t res;
    if (d == 64'd0) begin
      res.quo = (n == 64'd0) ? 64'd0 : ones;
      res.rem = 64'd0;
    end else begin
      res.quo = n / d;
      res.rem = n % d;
    end
    return res;
  endfunction

  function automatic div_result_t predict_division(func_t f, logic [63:0] n,
                                                   logic [63:0] d);
    div_result_t res;
    case (f)
      FUNC_S32: begin
        res = divide_signed({{32{n[31]}}, n[31:0]}, {{32{d[31]}}, d[31:0]},
                            64'h7FFF_FFFF, 64'h8000_0000);
        res.quo &= Low32;
        res.rem &= Low32;
      end
      FUNC_U32: res = divide_unsigned(n & Low32, d & Low32, Low32);
      FUNC_S64: res = divide_signed(n, d, ~Min64, Min64);
      default:  res = divide_unsigned(n, d, '1);
    endcase
    return res;
  endfunction

  class div_scoreboard;
    div_result_t pending[$];
    int checked = 0;

    function void note_input(func_t f, logic [63:0] n, logic [63:0] d);
      pending.push_back(predict_division(f, n, d));
    endfunction

    task check_result(logic [63:0] q, logic [63:0] r);
      div_result_t exp_res;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result q=%h r=%h", q, r));
        return;
      end
      exp_res = pending.pop_front();
      checked++;
      if (q !== exp_res.quo)
        report($sformatf("quotient %h, expected %h", q, exp_res.quo));
      if (r !== exp_res.rem)
        report($sformatf("remainder %h, expected %h", r, exp_res.rem));
    endtask
  endclass

  div_scoreboard quotients = new();

  // Input monitor: note every accepted beat.
  always @(posedge clk) begin
    cycles++;
    if (!rst && in_ch.valid && in_ch.ready)
      quotients.note_input(func_t'(in_ch.func), in_ch.dividend, in_ch.divisor);
  end

  // Output monitor: check every accepted beat.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      quotients.check_result(out_ch.quotient, out_ch.remainder);
  end

  // Receiver: ready in random bursts of stall, none once quiet.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 8);
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Send one beat; hold until accepted. Idle burst beforehand, at random.
  task automatic send_division(func_t f, logic [63:0] n, logic [63:0] d);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.dividend <= n;
    in_ch.divisor  <= d;
    if (d == 64'd0) n_zero_div++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic release_input();
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operand shaped for interesting cases: zero, small, extremes, upper-word patterns, shifted or fully random.
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom_range(0, 15)};
      2: v = -64'($urandom_range(1, 15));
      3: v = $urandom_range(0, 1) ? Min64 : 64'hFFFF_FFFF_8000_0000;
      4: v = {$urandom(), 32'h0} | ($urandom_range(0, 1) ? 64'h8000_0000 : 64'h0);
      5: v = rand64() >> $urandom_range(0, 63);
      default: v = rand64();
    endcase
    return v;
  endfunction

  initial begin
    func_t f;
    logic [63:0] n, d;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_S32;
    in_ch.dividend = '0;
    in_ch.divisor = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: ordinary divides in each mode, then the zero-divisor
    // saturation cases, the min / -1 wrap, and ignored upper bits.
    send_division(FUNC_S32, 64'd100, 64'd7);
    send_division(FUNC_S32, -64'sd100, 64'd7);
    send_division(FUNC_U32, 64'hFFFF_FFFF, 64'd16);
    send_division(FUNC_S64, -64'sd100, -64'sd7);
    send_division(FUNC_U64, '1, 64'd3);
    send_division(FUNC_S32, 64'd5, 64'd0);
    send_division(FUNC_S32, 64'hFFFF_FFFB, 64'd0);
    send_division(FUNC_S32, 64'd0, 64'd0);
    send_division(FUNC_U32, 64'd9, 64'hFFFF_FFFF_0000_0000);
    send_division(FUNC_U32, 64'd0, 64'd0);
    send_division(FUNC_S64, 64'd5, 64'd0);
    send_division(FUNC_S64, Min64, 64'd0);
    send_division(FUNC_S64, 64'd0, 64'd0);
    send_division(FUNC_U64, 64'd1, 64'd0);
    send_division(FUNC_U64, 64'd0, 64'd0);
    send_division(FUNC_S32, 64'h8000_0000, 64'hFFFF_FFFF);
    send_division(FUNC_S64, Min64, '1);
    send_division(FUNC_S32, 64'hDEAD_BEEF_0000_0064, 64'h1234_5678_FFFF_FFF9);
    send_division(FUNC_U64, Min64, '1);
    send_division(FUNC_U64, 64'd3, '1);
    send_division(FUNC_S64, ~Min64, 64'd1);
    send_division(FUNC_U32, '1, '1);

    // Drain completely before the random part.
    release_input();
    while (quotients.pending.size() != 0) @(negedge clk);

    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom * 4 / 5) quiet = 1'b1;   // last stretch at full rate
      f = func_t'($urandom_range(0, 3));
      n = pick_operand();
      d = ($urandom_range(0, 3) == 0) ? pick_operand() : rand64() >> $urandom_range(0, 62);
      if ($urandom_range(0, 30) == 0) d = '1;
      send_division(f, n, d);
      // One mid-run pause until the pipe is empty.
      if (i == NumRandom / 2) begin
        release_input();
        while (quotients.pending.size() != 0) @(negedge clk);
      end
    end
    release_input();

    while (quotients.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Covered %0d divides over all four modes, %0d with zero divisor,",
             quotients.checked, n_zero_div);
    $display("signed min by -1 wrap, ignored upper bits, and random stalls on both sides.");
    if (errors == 0)
      $display("integer_divider_zero_saturating test passed");
    else
      $display("integer_divider_zero_saturating test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("integer_divider_zero_saturating test failed");
      $finish;
    end
  end
endmodule
